// ===== rtl/bitmap_rank_query_macros.svh =====
// ---------------------------------------------------------------------------
// bitmap_rank_query_macros.svh
// Assertion shorthands for the bitmap rank unit.
// ---------------------------------------------------------------------------
`ifndef BITMAP_RANK_QUERY_MACROS_SVH
`define BITMAP_RANK_QUERY_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst is high.
`define BRQ_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk, off while rst is high.
`define BRQ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/brq_pkg.sv =====
// ---------------------------------------------------------------------------
// brq_pkg
// Shared constants, types and the popcount tree for the bitmap rank unit.
// ---------------------------------------------------------------------------
package brq_pkg;

  localparam int MAX_WORDS = 1024;
  localparam int ADDR_W    = $clog2(MAX_WORDS);
  localparam int COUNT_W   = $clog2(MAX_WORDS + 1);
  localparam int WORD_W    = 64;
  localparam int OFF_W     = 6;
  localparam int POS_W     = 17;
  localparam int RANK_W    = 17;
  localparam int POP_W     = 7;
  localparam int ACT_W     = 2;
  localparam int IN_DATA_W  = ((WORD_W + POS_W + 7) / 8) * 8;
  localparam int OUT_DATA_W = ((RANK_W + 7) / 8) * 8;

  localparam logic [ACT_W-1:0] ACT_CLEAR  = 2'd0;
  localparam logic [ACT_W-1:0] ACT_APPEND = 2'd1;
  localparam logic [ACT_W-1:0] ACT_RANK   = 2'd2;

  // one memory row: stored word plus count of ones in all earlier words
  typedef struct packed {
    logic [RANK_W-1:0] prefix;
    logic [WORD_W-1:0] word;
  } entry_t;

  // 64-bit popcount as a six-level adder tree
  function automatic logic [POP_W-1:0] popcount(input logic [WORD_W-1:0] v);
    logic [1:0] l1 [32];
    logic [2:0] l2 [16];
    logic [3:0] l3 [8];
    logic [4:0] l4 [4];
    logic [5:0] l5 [2];
    for (int i = 0; i < 32; i++) l1[i] = {1'b0, v[2*i]} + {1'b0, v[2*i+1]};
    for (int i = 0; i < 16; i++) l2[i] = {1'b0, l1[2*i]} + {1'b0, l1[2*i+1]};
    for (int i = 0; i < 8; i++)  l3[i] = {1'b0, l2[2*i]} + {1'b0, l2[2*i+1]};
    for (int i = 0; i < 4; i++)  l4[i] = {1'b0, l3[2*i]} + {1'b0, l3[2*i+1]};
    for (int i = 0; i < 2; i++)  l5[i] = {1'b0, l4[2*i]} + {1'b0, l4[2*i+1]};
    return {1'b0, l5[0]} + {1'b0, l5[1]};
  endfunction

endpackage

// ===== rtl/brq_store.sv =====
// ---------------------------------------------------------------------------
// brq_store
// Word and prefix memory: one write port, one read port, registered read.
// ---------------------------------------------------------------------------
module brq_store
  import brq_pkg::*;
(
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  entry_t            wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output entry_t            rd_data
);

  entry_t mem [MAX_WORDS];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== rtl/bitmap_rank_query.sv =====
// ---------------------------------------------------------------------------
// bitmap_rank_query
// Bitmap of 64-bit words with per-word prefix counts; answers rank requests.
// ---------------------------------------------------------------------------
// Throughput: one request per cycle (clear, append or rank), set by the single
//   memory access plus one 64-bit popcount per request, while no rank result
//   waits on a stalled output. A rank result goes through the memory read,
//   then mask/popcount/add into the output register.
// Reset: rst clears the word count, the running total and all valid flags.
//   Memory contents are not cleared; only rows written since the last clear
//   ever feed a result.
module bitmap_rank_query
  import brq_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  // request channel
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [IN_DATA_W-1:0]  s_tdata,   // [63:0] word, [80:64] position
  input  logic [ACT_W-1:0]      s_tuser,   // [1:0] action
  // result channel
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [OUT_DATA_W-1:0] m_tdata,   // [16:0] rank_value
  output logic                  m_tuser    // [0] out_of_range
);

  // ---- request decode ----------------------------------------------------
  logic              accept;
  logic [ACT_W-1:0]  action;
  logic [WORD_W-1:0] word;
  logic [POS_W-1:0]  position;

  assign accept   = s_tvalid && s_tready;
  assign action   = s_tuser;
  assign word     = s_tdata[WORD_W-1:0];
  assign position = s_tdata[WORD_W +: POS_W];

  // ---- bitmap bookkeeping ------------------------------------------------
  logic [COUNT_W-1:0] words_loaded;
  logic [RANK_W-1:0]  running_total;
  logic [POS_W-1:0]   loaded_bits;
  logic               full;
  logic               append_fire;
  logic               rank_fire;
  logic               clear_fire;

  // number of loaded bits is words_loaded * 64
  assign loaded_bits = POS_W'({words_loaded, {OFF_W{1'b0}}});
  assign full        = (words_loaded == COUNT_W'(MAX_WORDS));
  assign clear_fire  = accept && (action == ACT_CLEAR);
  assign append_fire = accept && (action == ACT_APPEND) && !full;
  assign rank_fire   = accept && (action == ACT_RANK);

  always_ff @(posedge clk) begin
    if (rst) begin
      words_loaded  <= '0;
      running_total <= '0;
    end else if (clear_fire) begin
      words_loaded  <= '0;
      running_total <= '0;
    end else if (append_fire) begin
      words_loaded  <= words_loaded + COUNT_W'(1);
      running_total <= running_total + RANK_W'(popcount(word));
    end
  end

  // ---- memory ------------------------------------------------------------
  // Append writes row words_loaded with the prefix before this word. A rank
  // reads row position/64. Rows whose data feeds a result are below words_loaded,
  // so they were written at an earlier edge; no forwarding is needed.
  entry_t wr_entry;
  entry_t rd_entry;

  assign wr_entry.prefix = running_total;
  assign wr_entry.word   = word;

  brq_store u_store (
    .clk     (clk),
    .wr_en   (append_fire),
    .wr_addr (words_loaded[ADDR_W-1:0]),
    .wr_data (wr_entry),
    .rd_en   (rank_fire),
    .rd_addr (position[OFF_W +: ADDR_W]),
    .rd_data (rd_entry)
  );

  // ---- stage 1: range checks captured with the read ----------------------
  logic              q_valid;
  logic              q_oor;
  logic              q_end;
  logic [RANK_W-1:0] q_total;
  logic [OFF_W-1:0]  q_off;
  logic              advance;

  // output register is free, or is being emptied this cycle
  assign advance  = !m_tvalid || m_tready;
  // hold off new requests while a read result waits, so rd_entry stays put
  assign s_tready = !q_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      q_valid <= 1'b0;
    end else if (rank_fire) begin
      q_valid <= 1'b1;
    end else if (advance) begin
      q_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rank_fire) begin
      q_oor   <= (position > loaded_bits);
      q_end   <= (position == loaded_bits);
      q_total <= running_total;
      q_off   <= position[OFF_W-1:0];
    end
  end

  // ---- stage 2: count the top q_off bits of the word ---------------------
  logic [WORD_W-1:0] head_bits;
  logic [RANK_W-1:0] rank_sum;
  logic [RANK_W-1:0] rank_next;

  // keep the top q_off bits (positions run from bit 63 downward)
  assign head_bits = rd_entry.word & ~({WORD_W{1'b1}} >> q_off);
  assign rank_sum  = rd_entry.prefix + RANK_W'(popcount(head_bits));

  always_comb begin
    if (q_oor) begin
      rank_next = '0;
    end else if (q_end) begin
      rank_next = q_total;
    end else begin
      rank_next = rank_sum;
    end
  end

  // ---- output register ---------------------------------------------------
  logic [RANK_W-1:0] rank_value;
  logic              out_of_range;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (q_valid && advance) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_valid && advance) begin
      rank_value   <= rank_next;
      out_of_range <= q_oor;
    end
  end

  assign m_tdata = OUT_DATA_W'(rank_value);
  assign m_tuser = out_of_range;

  // ---- assertions --------------------------------------------------------
  `include "bitmap_rank_query_macros.svh"

  `BRQ_ASSERT_NOW(a_count_in_range, 1'b1, words_loaded <= COUNT_W'(MAX_WORDS), "word count past capacity")
  `BRQ_ASSERT_NOW(a_oor_zero, m_tvalid && out_of_range, rank_value == '0, "out-of-range result with nonzero rank")
  `BRQ_ASSERT_NEXT(a_rank_staged, rank_fire, q_valid, "accepted rank request not staged")
  `BRQ_ASSERT_NEXT(a_clear_done, clear_fire, words_loaded == '0 && running_total == '0, "clear left state behind")

endmodule
